// ----- design/utf8vd_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 validating decoder.
`timescale 1ns / 1ps

package utf8vd_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [QPtrW-1:0] QPtrOne  = QPtrW'(1);
  localparam logic [QCntW-1:0] QCntOne  = QCntW'(1);
  localparam logic [QCntW-1:0] QCntFull = QCntW'(QueueDepth);

  localparam logic [CpW-1:0] ReplReset  = 21'h00FFFD;
  localparam logic [CpW-1:0] Min2Byte   = 21'h000080;
  localparam logic [CpW-1:0] Min3Byte   = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte   = 21'h010000;
  localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] MaxScalar  = 21'h10FFFF;

  // Continuation bytes announced by the open lead byte.
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_len_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           was_rejected;
    logic           run_last;
    logic           text_end;
  } out_t;

  // One decoded byte's worth of work: rej_count replacements, then an
  // optional code point.
  typedef struct packed {
    logic [2:0]     rej_count;
    logic           has_cp;
    logic [CpW-1:0] cp;
    logic           text_end;
  } cmd_t;

  function automatic logic [CpW-1:0] min_value(input seq_len_e len);
    logic [CpW-1:0] m;
    unique case (len)
      SEQ_TWO:   m = Min2Byte;
      SEQ_THREE: m = Min3Byte;
      SEQ_FOUR:  m = Min4Byte;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- design/utf8vd_front.sv -----
// Front end: byte classification, sequence state and command generation.
`timescale 1ns / 1ps

module utf8vd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  utf8vd_pkg::in_t    in_data_i,
  input  logic               q_full_i,
  output logic               in_ready_o,
  output logic               push_o,
  output utf8vd_pkg::cmd_t   cmd_o
);

  utf8vd_pkg::seq_len_e        exp_q, exp_d;
  logic [1:0]                  col_q, col_d;
  logic [utf8vd_pkg::CpW-1:0]  acc_q, acc_d;

  logic [7:0]                  b;
  logic                        accept;
  logic                        fresh;
  logic                        bad;
  logic [1:0]                  col_inc;
  logic [utf8vd_pkg::CpW-1:0]  acc_shift;
  logic [2:0]                  cnt;
  logic                        cp_v;
  logic [utf8vd_pkg::CpW-1:0]  cp;

  assign b          = in_data_i.data_byte;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_shift  = {acc_q[utf8vd_pkg::CpW-7:0], b[5:0]};
  assign col_inc    = col_q + 2'd1;
  assign bad = (acc_shift < utf8vd_pkg::min_value(exp_q))
            || ((acc_shift >= utf8vd_pkg::SurrLo) && (acc_shift <= utf8vd_pkg::SurrHi))
            || (acc_shift > utf8vd_pkg::MaxScalar);

  always_comb begin
    exp_d = exp_q;
    col_d = col_q;
    acc_d = acc_q;
    cnt   = 3'd0;
    cp_v  = 1'b0;
    cp    = '0;
    fresh = 1'b0;

    if (exp_q != utf8vd_pkg::SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        if (col_inc == exp_q) begin
          if (bad) begin
            cnt = {1'b0, exp_q} + 3'd1;
          end else begin
            cp_v = 1'b1;
            cp   = acc_shift;
          end
          exp_d = utf8vd_pkg::SEQ_NONE;
          col_d = 2'd0;
          acc_d = '0;
        end else begin
          col_d = col_inc;
          acc_d = acc_shift;
        end
      end else begin
        // interrupted: one replacement per byte consumed, then redecode
        cnt   = {1'b0, col_q} + 3'd1;
        exp_d = utf8vd_pkg::SEQ_NONE;
        col_d = 2'd0;
        acc_d = '0;
        fresh = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!b[7]) begin
        cp_v = 1'b1;
        cp   = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        exp_d = utf8vd_pkg::SEQ_TWO;
        col_d = 2'd0;
        acc_d = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        exp_d = utf8vd_pkg::SEQ_THREE;
        col_d = 2'd0;
        acc_d = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        exp_d = utf8vd_pkg::SEQ_FOUR;
        col_d = 2'd0;
        acc_d = {18'd0, b[2:0]};
      end else begin
        cnt = cnt + 3'd1;
      end
    end

    // end of text flushes an open sequence
    if (in_data_i.final_byte && (exp_d != utf8vd_pkg::SEQ_NONE)) begin
      cnt   = cnt + {1'b0, col_d} + 3'd1;
      exp_d = utf8vd_pkg::SEQ_NONE;
      col_d = 2'd0;
      acc_d = '0;
    end
  end

  assign cmd_o.rej_count = cnt;
  assign cmd_o.has_cp    = cp_v;
  assign cmd_o.cp        = cp;
  assign cmd_o.text_end  = in_data_i.final_byte;
  assign push_o          = accept && ((cnt != 3'd0) || cp_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= utf8vd_pkg::SEQ_NONE;
      col_q <= 2'd0;
      acc_q <= '0;
    end else if (accept) begin
      exp_q <= exp_d;
      col_q <= col_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ----- design/utf8vd_queue.sv -----
// Small command FIFO between front end and result sequencer.
`timescale 1ns / 1ps

module utf8vd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  utf8vd_pkg::cmd_t   cmd_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output utf8vd_pkg::cmd_t   head_o
);

  utf8vd_pkg::cmd_t                 mem_q [utf8vd_pkg::QueueDepth];
  logic [utf8vd_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [utf8vd_pkg::QCntW-1:0]     count_q;
  logic                             do_push, do_pop;

  assign full_o       = (count_q == utf8vd_pkg::QCntFull);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + utf8vd_pkg::QPtrOne;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + utf8vd_pkg::QPtrOne;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + utf8vd_pkg::QCntOne;
        2'b01:   count_q <= count_q - utf8vd_pkg::QCntOne;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- design/utf8vd_back.sv -----
// Result sequencer: expands queue heads into one result per cycle, unless stalled.
`timescale 1ns / 1ps

module utf8vd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  utf8vd_pkg::cmd_t            head_i,
  input  logic [utf8vd_pkg::CpW-1:0]  repl_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output utf8vd_pkg::out_t            out_data_o
);

  logic [1:0]        idx_q;
  logic              out_valid_q;
  utf8vd_pkg::out_t  out_q;
  logic [2:0]        total;
  logic              last_res;
  logic              is_rej;
  logic              load;

  assign total    = head_i.rej_count + {2'd0, head_i.has_cp};
  assign last_res = ({1'b0, idx_q} == (total - 3'd1));
  assign is_rej   = ({1'b0, idx_q} < head_i.rej_count);
  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = load && last_res;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.code_point   <= is_rej ? repl_i : head_i.cp;
      out_q.was_rejected <= is_rej;
      out_q.run_last     <= last_res;
      out_q.text_end     <= last_res && head_i.text_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_res ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- design/utf8_validating_decoder.sv -----
// Top level of the UTF-8 validating decoder with replacement.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | in        | in_valid_i/in_ready_o  | in_data_i  (utf8vd_pkg::in_t)
//   out     | out       | out_valid_o/out_ready_i| out_data_o (utf8vd_pkg::out_t)
//   cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (replacement char)
//
// One byte is accepted per cycle while the 4-entry command queue has room.
// Each byte gives 0 to 4 results; the result sequencer emits one per cycle while
// the output is ready. A byte's command passes through the queue and then the
// output register before its first result appears. Reset clears sequence state,
// the queue and the output valid flag and sets the replacement character to U+FFFD.
`timescale 1ns / 1ps

module utf8_validating_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  utf8vd_pkg::in_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output utf8vd_pkg::out_t            out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [utf8vd_pkg::CpW-1:0]  cfg_data_i
);

  logic [utf8vd_pkg::CpW-1:0] repl_q;
  logic                       q_full;
  logic                       push;
  logic                       pop;
  logic                       head_valid;
  utf8vd_pkg::cmd_t           cmd;
  utf8vd_pkg::cmd_t           head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= utf8vd_pkg::ReplReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repl_q <= cfg_data_i;
    end
  end

  utf8vd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  utf8vd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  utf8vd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .repl_i       (repl_q),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
